@@ hw/rtl/mpm_pkg.sv @@
// ----------------------------------------------------------------------------
// mpm_pkg
// Shared types, constants and helpers of the multi-pattern matcher.
// ----------------------------------------------------------------------------
package mpm_pkg;

  localparam int NODES    = 4096;
  localparam int ALPHABET = 26;
  localparam int NW       = $clog2(NODES);             // node number width
  localparam int CAW      = $clog2(NODES * ALPHABET);  // child table address width
  localparam int LW       = 5;                         // letter field width
  localparam int CNTW     = 16;

  localparam logic [1:0] OP_CLEAR   = 2'd0;
  localparam logic [1:0] OP_PATTERN = 2'd1;
  localparam logic [1:0] OP_BUILD   = 2'd2;
  localparam logic [1:0] OP_TEXT    = 2'd3;

  typedef struct packed {
    logic [1:0]    op;
    logic [LW-1:0] letter;
    logic          last;
    logic          in_range;
  } cmd_t;

  typedef struct packed {
    logic init_busy;
  } stat_t;

  function automatic logic [CAW-1:0] caddr(input logic [NW-1:0] node,
                                           input logic [LW-1:0] c);
    logic [CAW-1:0] base;
    base = CAW'(node) * CAW'(ALPHABET);
    return base + CAW'(c);
  endfunction

endpackage

@@ hw/rtl/mpm_if.sv @@
// ----------------------------------------------------------------------------
// mpm_in_if / mpm_out_if
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface mpm_in_if;
  import mpm_pkg::*;
  logic          valid;
  logic          ready;
  logic [1:0]    mode;
  logic [LW-1:0] letter;
  logic          last;
  modport source (output valid, mode, letter, last, input ready);
  modport sink   (input valid, mode, letter, last, output ready);
endinterface

interface mpm_out_if;
  import mpm_pkg::*;
  logic            valid;
  logic            ready;
  logic [CNTW-1:0] match_count;
  logic            status;
  modport source (output valid, match_count, status, input ready);
  modport sink   (input valid, match_count, status, output ready);
endinterface

@@ hw/rtl/mpm_ram.sv @@
// ----------------------------------------------------------------------------
// mpm_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module mpm_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);
  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ hw/rtl/mpm_front.sv @@
// ----------------------------------------------------------------------------
// mpm_front
// Accepts input items, classifies them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module mpm_front (
  input  logic          clk,
  input  logic          rst_n,
  mpm_in_if.sink        in_ch,
  input  mpm_pkg::stat_t stat,
  output logic          cmd_valid,
  output mpm_pkg::cmd_t cmd,
  input  logic          cmd_pop
);
  import mpm_pkg::*;

  cmd_t       q_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       push;
  cmd_t       c_in;

  assign in_ch.ready = (cnt_r != 2'd2) && !stat.init_busy;
  assign push        = in_ch.valid && in_ch.ready;
  assign cmd_valid   = (cnt_r != 2'd0);
  assign cmd         = q_r[rp_r];

  always_comb begin
    c_in.op       = in_ch.mode;
    c_in.letter   = in_ch.letter;
    c_in.last     = in_ch.last;
    c_in.in_range = (in_ch.letter < LW'(ALPHABET));
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= c_in;
    end
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wp_r <= !wp_r;
      end
      if (cmd_pop) begin
        rp_r <= !rp_r;
      end
      cnt_r <= cnt_r + 2'(push) - 2'(cmd_pop);
    end
  end
endmodule

@@ hw/rtl/mpm_back.sv @@
// ----------------------------------------------------------------------------
// mpm_back
// Sequencer that loads the trie, builds failure links and scans text.
// ----------------------------------------------------------------------------
module mpm_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cmd_valid,
  input  mpm_pkg::cmd_t  cmd,
  output logic           cmd_pop,
  output mpm_pkg::stat_t stat,
  mpm_out_if.source      out_ch
);
  import mpm_pkg::*;

  localparam logic [4:0] S_IDLE = 5'd0,  S_CLR = 5'd1,  S_P_RD = 5'd2,  S_P_DEC = 5'd3;
  localparam logic [4:0] S_P_ZERO = 5'd4, S_P_LINK = 5'd5, S_P_END = 5'd6, S_P_INC = 5'd7;
  localparam logic [4:0] S_B_RRD = 5'd8, S_B_RDEC = 5'd9, S_B_POP = 5'd10, S_B_U = 5'd11;
  localparam logic [4:0] S_B_FRD = 5'd12, S_B_FGOT = 5'd13, S_B_CUR = 5'd14, S_B_VIA = 5'd15;
  localparam logic [4:0] S_B_DEC = 5'd16, S_T_RD = 5'd17, S_T_STEP = 5'd18;
  localparam logic [4:0] S_T_WALK = 5'd19, S_T_ACC = 5'd20, S_T_END = 5'd21;

  logic [4:0]      state_r, state_nxt;
  cmd_t            cmd_r;
  logic [NW-1:0]   cursor_r, scan_r, node_r, fail_r, cur_r;
  logic [NW:0]     nodes_r, head_r, tail_r;
  logic [CNTW-1:0] total_r;
  logic            ovf_r, built_r, drop_r, init_r;
  logic [LW-1:0]   cnt_r;
  logic            out_valid_r;
  logic [CNTW-1:0] out_count_r;
  logic            out_status_r;

  // memory ports
  logic            ch_we;
  logic [CAW-1:0]  ch_wa, ch_ra;
  logic [NW-1:0]   ch_wd, ch_rd;
  logic            fl_we;
  logic [NW-1:0]   fl_wa, fl_ra, fl_wd, fl_rd;
  logic            kc_we;
  logic [NW-1:0]   kc_wa, kc_ra;
  logic [CNTW-1:0] kc_wd, kc_rd;
  logic            bq_we;
  logic [NW-1:0]   bq_wa, bq_ra, bq_wd, bq_rd;

  logic            last_letter;
  logic            tail_ok;
  logic [CNTW:0]   sum;
  logic            emit;

  mpm_ram #(.W(NW),   .D(NODES * ALPHABET)) u_child (.clk(clk), .we(ch_we), .waddr(ch_wa),
    .wdata(ch_wd), .raddr(ch_ra), .rdata(ch_rd));
  mpm_ram #(.W(NW),   .D(NODES)) u_fail  (.clk(clk), .we(fl_we), .waddr(fl_wa),
    .wdata(fl_wd), .raddr(fl_ra), .rdata(fl_rd));
  mpm_ram #(.W(CNTW), .D(NODES)) u_count (.clk(clk), .we(kc_we), .waddr(kc_wa),
    .wdata(kc_wd), .raddr(kc_ra), .rdata(kc_rd));
  mpm_ram #(.W(NW),   .D(NODES)) u_queue (.clk(clk), .we(bq_we), .waddr(bq_wa),
    .wdata(bq_wd), .raddr(bq_ra), .rdata(bq_rd));

  assign last_letter = (cnt_r == LW'(ALPHABET - 1));
  assign tail_ok     = (tail_r < (NW+1)'(NODES));
  assign sum         = {1'b0, total_r} + {1'b0, kc_rd};
  assign cmd_pop     = (state_r == S_IDLE) && cmd_valid;
  assign stat.init_busy = init_r;
  assign emit        = (state_r == S_T_END) && cmd_r.last && (!out_valid_r || out_ch.ready);

  assign out_ch.valid       = out_valid_r;
  assign out_ch.match_count = out_count_r;
  assign out_ch.status      = out_status_r;

  always_comb begin
    state_nxt = state_r;
    ch_we = 1'b0; ch_wa = '0; ch_wd = '0; ch_ra = '0;
    fl_we = 1'b0; fl_wa = '0; fl_wd = '0; fl_ra = '0;
    kc_we = 1'b0; kc_wa = '0; kc_wd = '0; kc_ra = '0;
    bq_we = 1'b0; bq_wa = '0; bq_wd = '0; bq_ra = '0;
    case (state_r)
      S_IDLE: begin
        if (cmd_valid) begin
          case (cmd.op)
            OP_CLEAR:   state_nxt = S_CLR;
            OP_PATTERN: state_nxt = built_r ? S_IDLE :
                                    (cmd.in_range && !drop_r) ? S_P_RD : S_P_END;
            OP_BUILD:   state_nxt = built_r ? S_IDLE : S_B_RRD;
            OP_TEXT:    state_nxt = cmd.in_range ? S_T_RD : S_T_END;
            default:    state_nxt = S_IDLE;
          endcase
        end
      end
      S_CLR: begin
        ch_we = 1'b1;
        ch_wa = caddr('0, cnt_r);
        if (last_letter) state_nxt = S_IDLE;
      end
      S_P_RD: begin
        ch_ra     = caddr(cursor_r, cmd_r.letter);
        state_nxt = S_P_DEC;
      end
      S_P_DEC: begin
        if (ch_rd != '0) state_nxt = S_P_END;
        else if (nodes_r == (NW+1)'(NODES)) state_nxt = S_P_END;
        else state_nxt = S_P_ZERO;
      end
      S_P_ZERO: begin
        ch_we = 1'b1; ch_wa = caddr(node_r, cnt_r);
        fl_we = 1'b1; fl_wa = node_r;
        kc_we = 1'b1; kc_wa = node_r;
        if (last_letter) state_nxt = S_P_LINK;
      end
      S_P_LINK: begin
        ch_we = 1'b1; ch_wa = caddr(cursor_r, cmd_r.letter); ch_wd = node_r;
        state_nxt = S_P_END;
      end
      S_P_END: begin
        kc_ra = cursor_r;
        state_nxt = (cmd_r.last && !drop_r) ? S_P_INC : S_IDLE;
      end
      S_P_INC: begin
        kc_we = 1'b1; kc_wa = cursor_r;
        kc_wd = kc_rd + CNTW'(kc_rd != '1);
        state_nxt = S_IDLE;
      end
      S_B_RRD: begin
        ch_ra     = caddr('0, cnt_r);
        state_nxt = S_B_RDEC;
      end
      S_B_RDEC: begin
        if (ch_rd != '0 && tail_ok) begin
          fl_we = 1'b1; fl_wa = ch_rd;
          bq_we = 1'b1; bq_wa = tail_r[NW-1:0]; bq_wd = ch_rd;
        end
        state_nxt = last_letter ? S_B_POP : S_B_RRD;
      end
      S_B_POP: begin
        bq_ra     = head_r[NW-1:0];
        state_nxt = (head_r == tail_r) ? S_IDLE : S_B_U;
      end
      S_B_U:    state_nxt = S_B_FRD;
      S_B_FRD: begin
        fl_ra     = node_r;
        state_nxt = S_B_FGOT;
      end
      S_B_FGOT: state_nxt = S_B_CUR;
      S_B_CUR: begin
        ch_ra     = caddr(node_r, cnt_r);
        state_nxt = S_B_VIA;
      end
      S_B_VIA: begin
        ch_ra     = caddr(fail_r, cnt_r);
        state_nxt = S_B_DEC;
      end
      S_B_DEC: begin
        if (cur_r != '0) begin
          if (tail_ok) begin
            bq_we = 1'b1; bq_wa = tail_r[NW-1:0]; bq_wd = cur_r;
          end
          fl_we = 1'b1; fl_wa = cur_r; fl_wd = ch_rd;
        end else begin
          ch_we = 1'b1; ch_wa = caddr(node_r, cnt_r); ch_wd = ch_rd;
        end
        state_nxt = last_letter ? S_B_POP : S_B_CUR;
      end
      S_T_RD: begin
        ch_ra     = caddr(scan_r, cmd_r.letter);
        state_nxt = S_T_STEP;
      end
      S_T_STEP: state_nxt = S_T_WALK;
      S_T_WALK: begin
        kc_ra = node_r;
        fl_ra = node_r;
        state_nxt = (node_r == '0) ? S_T_END : S_T_ACC;
      end
      S_T_ACC: begin
        kc_we = 1'b1; kc_wa = node_r;
        state_nxt = S_T_WALK;
      end
      S_T_END: begin
        if (!cmd_r.last) state_nxt = S_IDLE;
        else if (!out_valid_r || out_ch.ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      init_r      <= 1'b1;
      cnt_r       <= '0;
      nodes_r     <= (NW+1)'(1);
      cursor_r    <= '0;
      scan_r      <= '0;
      total_r     <= '0;
      ovf_r       <= 1'b0;
      built_r     <= 1'b0;
      drop_r      <= 1'b0;
      head_r      <= '0;
      tail_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          cnt_r <= '0;
          if (cmd_valid) begin
            cmd_r <= cmd;
            if (cmd.op == OP_CLEAR) begin
              nodes_r  <= (NW+1)'(1);
              cursor_r <= '0;
              scan_r   <= '0;
              total_r  <= '0;
              ovf_r    <= 1'b0;
              built_r  <= 1'b0;
              drop_r   <= 1'b0;
            end else if (cmd.op == OP_BUILD && !built_r) begin
              built_r <= 1'b1;
              head_r  <= '0;
              tail_r  <= '0;
            end
          end
        end
        S_CLR: begin
          cnt_r <= cnt_r + LW'(1);
          if (last_letter) init_r <= 1'b0;
        end
        S_P_DEC: begin
          cnt_r <= '0;
          if (ch_rd != '0) begin
            cursor_r <= ch_rd;
          end else if (nodes_r == (NW+1)'(NODES)) begin
            ovf_r  <= 1'b1;
            drop_r <= 1'b1;
          end else begin
            node_r  <= nodes_r[NW-1:0];
            nodes_r <= nodes_r + (NW+1)'(1);
          end
        end
        S_P_ZERO: cnt_r <= cnt_r + LW'(1);
        S_P_LINK: cursor_r <= node_r;
        S_P_END: begin
          if (cmd_r.last) begin
            drop_r <= 1'b0;
            if (drop_r) cursor_r <= '0;
          end
        end
        S_P_INC:  cursor_r <= '0;
        S_B_RDEC: begin
          cnt_r <= last_letter ? '0 : cnt_r + LW'(1);
          if (ch_rd != '0 && tail_ok) tail_r <= tail_r + (NW+1)'(1);
        end
        S_B_POP: begin
          if (head_r != tail_r) head_r <= head_r + (NW+1)'(1);
        end
        S_B_U:    node_r <= bq_rd;
        S_B_FGOT: begin
          fail_r <= fl_rd;
          cnt_r  <= '0;
        end
        S_B_VIA:  cur_r <= ch_rd;
        S_B_DEC: begin
          cnt_r <= last_letter ? '0 : cnt_r + LW'(1);
          if (cur_r != '0 && tail_ok) tail_r <= tail_r + (NW+1)'(1);
        end
        S_T_STEP: begin
          scan_r <= ch_rd;
          node_r <= ch_rd;
        end
        S_T_ACC: begin
          total_r <= sum[CNTW] ? '1 : sum[CNTW-1:0];
          node_r  <= fl_rd;
        end
        S_T_END: begin
          // result leaves through the output register
          if (emit) begin
            out_count_r  <= total_r;
            out_status_r <= ovf_r;
            total_r      <= '0;
            scan_r       <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  a_nodes_range: assert property (@(posedge clk) disable iff (!rst_n)
    nodes_r != '0 && nodes_r <= (NW+1)'(NODES))
    else $error("node count out of range");
  a_queue_order: assert property (@(posedge clk) disable iff (!rst_n)
    head_r <= tail_r)
    else $error("bfs queue head passed tail");
  a_drop_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    drop_r |-> ovf_r)
    else $error("dropping pattern without overflow");
  a_emit_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_T_END)
    else $error("result raised outside end of text");
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |=> state_r != S_IDLE || $past(cmd.op) == OP_PATTERN
              || $past(cmd.op) == OP_BUILD)
    else $error("command popped without work");
endmodule

@@ hw/rtl/multi_pattern_matcher_top.sv @@
// ----------------------------------------------------------------------------
// multi_pattern_matcher_top
// Aho-Corasick keyword matcher over a 26-letter alphabet.
// ----------------------------------------------------------------------------
// Items are queued by the front end and run one at a time by the sequencer.
// A text letter walks its failure chain, reading the count and link stores
// once per chain node; when a pattern letter allocates a node, its child row
// is cleared one entry per cycle through the single child table write port.
// Build sweeps the root row, then visits each stored node letter by letter.
// Clear and reset both sweep the root row; no item is accepted during that
// pass after reset. The final text letter produces one result, and waits
// while an earlier result is still held.
module multi_pattern_matcher_top (
  input logic        clk,
  input logic        rst_n,
  mpm_in_if.sink     in_ch,
  mpm_out_if.source  out_ch
);
  import mpm_pkg::*;

  logic  cmd_valid, cmd_pop;
  cmd_t  cmd;
  stat_t stat;

  mpm_front u_front (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .stat(stat),
    .cmd_valid(cmd_valid), .cmd(cmd), .cmd_pop(cmd_pop));

  mpm_back u_back (.clk(clk), .rst_n(rst_n), .cmd_valid(cmd_valid), .cmd(cmd),
    .cmd_pop(cmd_pop), .stat(stat), .out_ch(out_ch));
endmodule
